>>> hdl/sha_pkg.sv
// Package with SHA-256 types, constants and round functions.
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } ctrl_state_t;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t INIT_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> hdl/sha_round.sv
// One SHA-256 round with its message schedule step, shared by all 64 rounds.
`default_nettype none
module sha_round
    import sha_pkg::*;
(
    input  wire logic [5:0] round_idx,
    input  wire word_t      work_in [8],
    input  wire word_t      sched_in [16],
    output word_t           work_out [8],
    output word_t           sched_out [16]
);
    word_t w, w15, w2, sig0, sig1, s1, ch, s0, maj, t1, t2;
    always_comb begin
        w15  = sched_in[1];
        w2   = sched_in[14];
        sig0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        sig1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        // The window always holds the current word at index 0.
        w    = sched_in[0];
        for (int i = 0; i < 15; i++) begin
            sched_out[i] = sched_in[i + 1];
        end
        sched_out[15] = sched_in[0] + sig0 + sched_in[9] + sig1;
        s1  = rotr(work_in[4], 6) ^ rotr(work_in[4], 11) ^ rotr(work_in[4], 25);
        ch  = (work_in[4] & work_in[5]) ^ (~work_in[4] & work_in[6]);
        t1  = work_in[7] + s1 + ch + ROUND_K[round_idx] + w;
        s0  = rotr(work_in[0], 2) ^ rotr(work_in[0], 13) ^ rotr(work_in[0], 22);
        maj = (work_in[0] & work_in[1]) ^ (work_in[0] & work_in[2])
            ^ (work_in[1] & work_in[2]);
        t2  = s0 + maj;
        work_out[7] = work_in[6];
        work_out[6] = work_in[5];
        work_out[5] = work_in[4];
        work_out[4] = work_in[3] + t1;
        work_out[3] = work_in[2];
        work_out[2] = work_in[1];
        work_out[1] = work_in[0];
        work_out[0] = t1 + t2;
    end
endmodule
`default_nettype wire

>>> hdl/sha256_message_digest.sv
// Top level of the byte-serial SHA-256 message digest.
// An ordinary byte is only written into the block buffer; the byte that fills a block
// also starts a compression (one load, 64 rounds on the shared round unit, one fold).
// End of message adds the padding bytes and one or two compressed blocks,
// then the digest waits in output registers until the request is taken.
// Synchronous active-low reset loads the initial hash words and clears counts.
`default_nettype none
module sha256_message_digest
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_end_of_message,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_digest_part0,
    output logic [63:0]      m_digest_part1,
    output logic [63:0]      m_digest_part2,
    output logic [63:0]      m_digest_part3
);
    ctrl_state_t state_reg, state_next;

    // Block buffer is kept as sixteen big-endian words, filled a byte at a time.
    word_t       buf_reg [16];
    word_t       chain_reg [8];
    word_t       work_reg [8];
    word_t       sched_reg [16];
    word_t       work_rnd [8];
    word_t       sched_rnd [16];
    logic [28:0] count_reg;
    logic [5:0]  round_reg;
    logic [5:0]  pad_pos_reg;
    logic        final_reg;   // the block being compressed carries the length
    logic        padding_reg; // inside the end-of-message sequence

    sha_round u_round (
        .round_idx (round_reg),
        .work_in   (work_reg),
        .sched_in  (sched_reg),
        .work_out  (work_rnd),
        .sched_out (sched_rnd)
    );

    logic        accept;
    logic [5:0]  pos;
    logic [28:0] count_inc;
    logic [31:0] bit_len;
    logic [7:0]  pad_byte;
    logic [5:0]  end_pos;
    assign accept    = s_valid && s_ready;
    assign pos       = count_reg[5:0];
    assign count_inc = count_reg + 29'd1;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_has_byte && pos == 6'd63) begin
                        state_next = ST_LOAD;
                    end else if (s_end_of_message) begin
                        // A pad byte in the last slot leaves nothing to fill.
                        if (end_pos == 6'd63) begin
                            state_next = ST_LOAD;
                        end else begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: begin
                if (round_reg == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (final_reg) begin
                    state_next = ST_OUT;
                end else if (padding_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                if (pad_pos_reg == 6'd63) begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_OUT:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_digest_part0 = {chain_reg[0], chain_reg[1]};
    assign m_digest_part1 = {chain_reg[2], chain_reg[3]};
    assign m_digest_part2 = {chain_reg[4], chain_reg[5]};
    assign m_digest_part3 = {chain_reg[6], chain_reg[7]};

    // Byte written during padding: the pad byte first, zeros, then the length.
    always_comb begin
        bit_len = {count_reg, 3'b000};
        pad_byte = 8'h00;
        if (final_reg) begin
            case (pad_pos_reg)
                // When the message filled its last block exactly, the pad
                // byte opens the length block.
                6'd0:    pad_byte = (pos == 6'd0) ? PAD_BYTE : 8'h00;
                6'd60:   pad_byte = bit_len[31:24];
                6'd61:   pad_byte = bit_len[23:16];
                6'd62:   pad_byte = bit_len[15:8];
                6'd63:   pad_byte = bit_len[7:0];
                default: pad_byte = 8'h00;
            endcase
        end
        end_pos = s_has_byte ? count_inc[5:0] : pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            round_reg   <= '0;
            pad_pos_reg <= '0;
            final_reg   <= 1'b0;
            padding_reg <= 1'b0;
            chain_reg   <= INIT_WORDS;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_has_byte) begin
                            buf_reg[pos[5:2]][8*(3-pos[1:0]) +: 8] <= s_data_byte;
                            count_reg <= count_inc;
                        end
                        if (s_end_of_message) begin
                            padding_reg <= 1'b1;
                            // After a full block the pad byte goes into the next one.
                            if (!(s_has_byte && pos == 6'd63)) begin
                                buf_reg[end_pos[5:2]][8*(3-end_pos[1:0]) +: 8] <= PAD_BYTE;
                                pad_pos_reg <= end_pos + 6'd1;
                                final_reg   <= (end_pos < 6'd56);
                            end else begin
                                pad_pos_reg <= 6'd0;
                                final_reg   <= 1'b0;
                            end
                        end
                    end
                end
                ST_LOAD: begin
                    work_reg  <= chain_reg;
                    sched_reg <= buf_reg;
                    round_reg <= '0;
                end
                ST_ROUND: begin
                    work_reg  <= work_rnd;
                    sched_reg <= sched_rnd;
                    round_reg <= round_reg + 6'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                    // The next padding block is the one that carries the length.
                    if (padding_reg && !final_reg) begin
                        final_reg <= 1'b1;
                    end
                end
                ST_PAD: begin
                    buf_reg[pad_pos_reg[5:2]][8*(3-pad_pos_reg[1:0]) +: 8] <= pad_byte;
                    pad_pos_reg <= pad_pos_reg + 6'd1;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        chain_reg   <= INIT_WORDS;
                        count_reg   <= '0;
                        padding_reg <= 1'b0;
                        final_reg   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
